>>> rtl/core/u8u16_pkg.sv
// Shared types and codes for the UTF-8 to UTF-16 column converter.
package u8u16_pkg;

   // Result error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BAD_UTF8 = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG = 2'd2;

   // Allowed range of the next continuation byte
   localparam logic [2:0] RANGE_80_BF = 3'd0;
   localparam logic [2:0] RANGE_A0_BF = 3'd1;
   localparam logic [2:0] RANGE_80_9F = 3'd2;
   localparam logic [2:0] RANGE_90_BF = 3'd3;
   localparam logic [2:0] RANGE_80_8F = 3'd4;

   localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

   // Running decoder state for one line
   typedef struct packed {
      logic [16:0] byte_count;
      logic [16:0] utf16_count;
      logic [1:0]  cont_left;
      logic [2:0]  seq_len;
      logic [2:0]  next_range;
      logic [15:0] best_byte;
      logic [15:0] best_utf16;
      logic        bad_seen;
      logic        too_long_seen;
   } state_type;

   // Result fields of one line
   typedef struct packed {
      logic [15:0] snapped_byte_col;
      logic [15:0] utf16_column;
      logic [1:0]  error_code;
   } result_type;

endpackage

>>> rtl/core/u8u16_step.sv
// Next-state and result logic of the UTF-8 decoder for one item.
module u8u16_step #(
   parameter int MAX_LINE_BYTES = 65535
) (
   input  u8u16_pkg::state_type  cur_state,
   input  logic [7:0]            line_byte,
   input  logic                  has_byte,
   input  logic                  end_of_line,
   input  logic signed [31:0]    request_column,
   output u8u16_pkg::state_type  next_state,
   output u8u16_pkg::result_type result
);

   // Too long once the count passes the smaller of the limit and 65535
   localparam logic [16:0] LINE_LIMIT =
      17'((MAX_LINE_BYTES > 65535) ? 65535 : MAX_LINE_BYTES);

   u8u16_pkg::state_type st;
   logic        complete;
   logic [1:0]  units;
   logic [17:0] utf16_sum;
   logic        at_or_before;
   logic        bad_final;

   function automatic logic in_range(input logic [2:0] code, input logic [7:0] b);
      logic ok;
      unique case (code)
         u8u16_pkg::RANGE_A0_BF: ok = (b >= 8'hA0) && (b <= 8'hBF);
         u8u16_pkg::RANGE_80_9F: ok = (b >= 8'h80) && (b <= 8'h9F);
         u8u16_pkg::RANGE_90_BF: ok = (b >= 8'h90) && (b <= 8'hBF);
         u8u16_pkg::RANGE_80_8F: ok = (b >= 8'h80) && (b <= 8'h8F);
         default:                ok = (b >= 8'h80) && (b <= 8'hBF);
      endcase
      return ok;
   endfunction

   always_comb begin
      st           = cur_state;
      complete     = 1'b0;
      units        = 2'd1;
      utf16_sum    = '0;
      at_or_before = 1'b0;

      if (has_byte) begin
         if (st.byte_count != u8u16_pkg::COUNT_MAX) begin
            st.byte_count = st.byte_count + 17'd1;
         end
         if (st.byte_count > LINE_LIMIT) begin
            st.too_long_seen = 1'b1;
         end

         if (st.cont_left == 2'd0) begin
            // Lead byte: pick the sequence length and second-byte range
            priority if (line_byte < 8'h80) begin
               complete = 1'b1;
            end else if (line_byte >= 8'hC2 && line_byte <= 8'hDF) begin
               st.seq_len = 3'd2; st.cont_left = 2'd1;
               st.next_range = u8u16_pkg::RANGE_80_BF;
            end else if (line_byte == 8'hE0) begin
               st.seq_len = 3'd3; st.cont_left = 2'd2;
               st.next_range = u8u16_pkg::RANGE_A0_BF;
            end else if (line_byte == 8'hED) begin
               st.seq_len = 3'd3; st.cont_left = 2'd2;
               st.next_range = u8u16_pkg::RANGE_80_9F;
            end else if (line_byte >= 8'hE1 && line_byte <= 8'hEF) begin
               st.seq_len = 3'd3; st.cont_left = 2'd2;
               st.next_range = u8u16_pkg::RANGE_80_BF;
            end else if (line_byte == 8'hF0) begin
               st.seq_len = 3'd4; st.cont_left = 2'd3;
               st.next_range = u8u16_pkg::RANGE_90_BF;
            end else if (line_byte >= 8'hF1 && line_byte <= 8'hF3) begin
               st.seq_len = 3'd4; st.cont_left = 2'd3;
               st.next_range = u8u16_pkg::RANGE_80_BF;
            end else if (line_byte == 8'hF4) begin
               st.seq_len = 3'd4; st.cont_left = 2'd3;
               st.next_range = u8u16_pkg::RANGE_80_8F;
            end else begin
               st.bad_seen = 1'b1; st.cont_left = 2'd0;
               st.seq_len = 3'd0; st.next_range = u8u16_pkg::RANGE_80_BF;
            end
         end else if (in_range(st.next_range, line_byte)) begin
            st.next_range = u8u16_pkg::RANGE_80_BF;
            st.cont_left  = st.cont_left - 2'd1;
            if (st.cont_left == 2'd0) begin
               complete = 1'b1;
               units    = (st.seq_len == 3'd4) ? 2'd2 : 2'd1;
            end
         end else begin
            // Drop the open sequence; restart at the next byte
            st.bad_seen = 1'b1; st.cont_left = 2'd0;
            st.seq_len = 3'd0; st.next_range = u8u16_pkg::RANGE_80_BF;
         end
      end

      if (complete) begin
         utf16_sum = {1'b0, st.utf16_count} + {16'd0, units};
         st.utf16_count = (utf16_sum > {1'b0, u8u16_pkg::COUNT_MAX}) ?
                          u8u16_pkg::COUNT_MAX : utf16_sum[16:0];
         st.seq_len    = 3'd0;
         st.next_range = u8u16_pkg::RANGE_80_BF;
         at_or_before  = !request_column[31] &&
                         ({15'd0, st.byte_count} <= $unsigned(request_column));
         if (!st.too_long_seen && at_or_before) begin
            st.best_byte  = st.byte_count[15:0];
            st.best_utf16 = st.utf16_count[15:0];
         end
      end
   end

   assign bad_final = st.bad_seen || (st.cont_left != 2'd0);

   always_comb begin
      result = '0;
      priority if (st.too_long_seen) begin
         result.error_code = u8u16_pkg::ERR_TOO_LONG;
      end else if (bad_final) begin
         result.error_code = u8u16_pkg::ERR_BAD_UTF8;
      end else begin
         result.snapped_byte_col = st.best_byte;
         result.utf16_column     = st.best_utf16;
         result.error_code       = u8u16_pkg::ERR_NONE;
      end
   end

   // Clear the line state with the line-end item that yields its result
   assign next_state = end_of_line ? '0 : st;

endmodule

>>> rtl/core/utf8_column_to_utf16_column.sv
// Top level of the UTF-8 byte column to UTF-16 column converter.
//
// The block takes one UTF-8 line a byte per item and, on the item marked by
// req_tlast, returns one result: the requested byte column clamped to
// [0, line length] and snapped back to the last code-point boundary, with the
// UTF-16 code-unit offset of that boundary. The line is checked for
// well-formed UTF-8 (no overlongs, surrogates, values above U+10FFFF, stray or
// truncated sequences); error_code 1 flags ill-formed text, 2 flags a line
// longer than MAX_LINE_BYTES (or 65535) and wins over 1, and both columns read
// 0 with an error. An item with req_tuser low carries no byte; with req_tlast
// it ends the line, empty or not, and otherwise it is ignored. The request
// column is sampled with every byte and compared against each boundary that
// byte completes. Throughput is one item per clock while the input is not
// stalled. The last item of a line passes from the input register through the
// combinational decoder into the result register. The input side keeps taking
// items while a result waits, and stalls only when a second line end meets a
// result not yet taken.
module utf8_column_to_utf16_column #(
   parameter int MAX_LINE_BYTES = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] line_byte, [39:8] request_column
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // end_of_line
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [15:0] snapped byte column,
                                    // [31:16] utf16_column, [33:32] error_code,
                                    // [39:34] zero
);

   // Input register
   logic               s1_valid_ff;
   logic [7:0]         s1_byte_ff;
   logic               s1_has_ff;
   logic               s1_eol_ff;
   logic signed [31:0] s1_col_ff;
   logic               s1_advance;

   // Line state
   u8u16_pkg::state_type  state_ff;
   u8u16_pkg::state_type  state_in;
   u8u16_pkg::result_type result_in;

   // Result register
   logic                  rsp_valid_ff;
   u8u16_pkg::result_type rsp_ff;

   // Hold a line end while the result register still holds an untaken item
   assign s1_advance = s1_valid_ff && !(s1_eol_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_byte_ff <= req_tdata[7:0];
         s1_col_ff  <= req_tdata[39:8];
         s1_has_ff  <= req_tuser;
         s1_eol_ff  <= req_tlast;
      end
   end

   u8u16_step #(
      .MAX_LINE_BYTES(MAX_LINE_BYTES)
   ) u_step (
      .cur_state      (state_ff),
      .line_byte      (s1_byte_ff),
      .has_byte       (s1_has_ff),
      .end_of_line    (s1_eol_ff),
      .request_column (s1_col_ff),
      .next_state     (state_in),
      .result         (result_in)
   );

   // Advance the line state with every item that leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (s1_advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_eol_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_eol_ff) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.error_code, rsp_ff.utf16_column,
                        rsp_ff.snapped_byte_col};

`ifndef ASSERT_OFF
   // An error result carries zero columns
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.error_code != u8u16_pkg::ERR_NONE) |->
         (rsp_ff.snapped_byte_col == 16'd0) && (rsp_ff.utf16_column == 16'd0))
      else $error("error result with nonzero columns");

   // A boundary never has more UTF-16 units than bytes
   a_units_le_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.utf16_column <= rsp_ff.snapped_byte_col))
      else $error("utf16 column beyond byte column");

   // A line end leaves a clean state behind
   a_clear_after_eol: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_eol_ff |=>
         (state_ff.byte_count == 17'd0) && (state_ff.cont_left == 2'd0) &&
         !state_ff.bad_seen && !state_ff.too_long_seen)
      else $error("line state not cleared after line end");

   // Open continuations always sit inside a sequence of matching length
   a_seq_consistent: assert property (@(posedge clock) disable iff (reset)
      (state_ff.cont_left != 2'd0) |->
         ({1'b0, state_ff.cont_left} < state_ff.seq_len) &&
         (state_ff.seq_len >= 3'd2) && (state_ff.seq_len <= 3'd4))
      else $error("continuation count out of step with sequence length");

   // A line end waits only behind an untaken result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |-> s1_eol_ff && rsp_valid_ff)
      else $error("input register stalled without cause");
`endif

endmodule

>>> verif/u8u16_column_check_pkg.sv
// Column predictor and result checker for the UTF-8 to UTF-16 column converter.
`timescale 1ns / 100ps

package u8u16_column_check_pkg;

   class column_tracker;

      // Neither the length limit nor the 16-bit output may be exceeded; both are 65535 here.
      localparam logic [16:0] LINE_LIMIT = 17'd65535;

      u8u16_pkg::state_type  st;
      u8u16_pkg::result_type expected_columns[$];
      int                    errors;

      function new();
         st = '0;
         errors = 0;
      endfunction

      function void start_seq(logic [2:0] len, logic [2:0] span);
         st.seq_len = len;
         st.cont_left = 2'(len - 3'd1);
         st.next_range = span;
      endfunction

      // Close a code point; keep it as the best boundary if it lies at or before the column.
      function void close_code_point(int units, int col);
         int sum;
         sum = int'(st.utf16_count) + units;
         st.utf16_count = (sum > u8u16_pkg::COUNT_MAX) ? u8u16_pkg::COUNT_MAX : 17'(sum);
         st.seq_len = '0;
         st.next_range = u8u16_pkg::RANGE_80_BF;
         if (!st.too_long_seen && int'(st.byte_count) <= col) begin
            st.best_byte = st.byte_count[15:0];
            st.best_utf16 = st.utf16_count[15:0];
         end
      endfunction

      function void flag_bad();
         st.bad_seen = 1'b1;
         st.cont_left = '0;
         st.seq_len = '0;
         st.next_range = u8u16_pkg::RANGE_80_BF;
      endfunction

      // Advance the decoder by one accepted item; queue a result on a line end.
      function void take_item(logic [7:0] b, bit has, bit eol, int col);
         bit                    fits;
         u8u16_pkg::result_type r;
         if (has) begin
            if (st.byte_count < u8u16_pkg::COUNT_MAX)
               st.byte_count++;
            if (st.byte_count > LINE_LIMIT)
               st.too_long_seen = 1'b1;
            if (st.cont_left == 0) begin
               if (b < 8'h80)
                  close_code_point(1, col);
               else if (b >= 8'hC2 && b <= 8'hDF)
                  start_seq(3'd2, u8u16_pkg::RANGE_80_BF);
               else if (b == 8'hE0)
                  start_seq(3'd3, u8u16_pkg::RANGE_A0_BF);
               else if (b == 8'hED)
                  start_seq(3'd3, u8u16_pkg::RANGE_80_9F);
               else if (b >= 8'hE1 && b <= 8'hEF)
                  start_seq(3'd3, u8u16_pkg::RANGE_80_BF);
               else if (b == 8'hF0)
                  start_seq(3'd4, u8u16_pkg::RANGE_90_BF);
               else if (b >= 8'hF1 && b <= 8'hF3)
                  start_seq(3'd4, u8u16_pkg::RANGE_80_BF);
               else if (b == 8'hF4)
                  start_seq(3'd4, u8u16_pkg::RANGE_80_8F);
               else
                  flag_bad();
            end else begin
               case (st.next_range)
                  u8u16_pkg::RANGE_A0_BF: fits = (b >= 8'hA0 && b <= 8'hBF);
                  u8u16_pkg::RANGE_80_9F: fits = (b >= 8'h80 && b <= 8'h9F);
                  u8u16_pkg::RANGE_90_BF: fits = (b >= 8'h90 && b <= 8'hBF);
                  u8u16_pkg::RANGE_80_8F: fits = (b >= 8'h80 && b <= 8'h8F);
                  default:                fits = (b >= 8'h80 && b <= 8'hBF);
               endcase
               if (fits) begin
                  st.next_range = u8u16_pkg::RANGE_80_BF;
                  st.cont_left--;
                  if (st.cont_left == 0)
                     close_code_point((st.seq_len == 3'd4) ? 2 : 1, col);
               end else begin
                  flag_bad();
               end
            end
         end
         if (!eol)
            return;
         if (st.cont_left != 0)
            st.bad_seen = 1'b1;
         r = '0;
         if (st.too_long_seen)
            r.error_code = u8u16_pkg::ERR_TOO_LONG;
         else if (st.bad_seen)
            r.error_code = u8u16_pkg::ERR_BAD_UTF8;
         else begin
            r.error_code = u8u16_pkg::ERR_NONE;
            r.snapped_byte_col = st.best_byte;
            r.utf16_column = st.best_utf16;
         end
         expected_columns.insert(expected_columns.size(), r);
         st = '0;
      endfunction

      function void check_result(logic [39:0] data);
         u8u16_pkg::result_type want;
         if (expected_columns.size() == 0) begin
            $display("%0t: result %h with no line pending", $time, data);
            errors++;
            return;
         end
         want = expected_columns.pop_front();
         if (data[15:0] !== want.snapped_byte_col) begin
            $display("%0t: snapped byte column expected %0d actual %0d", $time,
                     want.snapped_byte_col, data[15:0]);
            errors++;
         end
         if (data[31:16] !== want.utf16_column) begin
            $display("%0t: utf16_column expected %0d actual %0d", $time,
                     want.utf16_column, data[31:16]);
            errors++;
         end
         if (data[33:32] !== want.error_code) begin
            $display("%0t: error_code expected %0d actual %0d", $time,
                     want.error_code, data[33:32]);
            errors++;
         end
      endfunction

      function int pending();
         return expected_columns.size();
      endfunction

   endclass

endpackage

>>> verif/utf8_column_to_utf16_column_test.sv
// Self-checking testbench for the UTF-8 to UTF-16 column converter.
`timescale 1ns / 100ps

module utf8_column_to_utf16_column_test;

   // Receiver hold-off used to back the block up until it stalls its input.
   localparam int HOLD_CYCLES = 400;
   // Items per random phase; ignored items (no byte, no line end) do not count.
   localparam int PHASE_ITEMS = 275;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;    // [7:0] line_byte, [39:8] request_column
   logic        req_tuser = 1'b0;  // [0] has_byte
   logic        req_tlast = 1'b0;  // end_of_line
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [15:0] snapped byte column, [31:16] utf16_column,
                                   // [33:32] error_code, [39:34] zero

   u8u16_column_check_pkg::column_tracker tracker;

   // Bytes of the line being built for the sender.
   logic [7:0] line_buf[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int noise_pct = 0;
   int items_sent = 0;
   int hold_count = 0;
   bit pressure_go = 1'b0;

   utf8_column_to_utf16_column dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Watchdog: the slowest correct run needs well under a tenth of this.
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   // Receiver: stall at random, or hold off for a long stretch once pressure is asked.
   always @(negedge clock) begin
      if (pressure_go && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check every result taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tdata);
   end

   // Append one byte to the line being built.
   function automatic void add_byte(logic [7:0] b);
      line_buf.insert(line_buf.size(), b);
   endfunction

   // Append one well-formed code point of the given UTF-8 length, often at a range end.
   function automatic void put_code_point(int len);
      int lo, hi, cp;
      case (len)
         1:       begin lo = 'h0;     hi = 'h7F;     end
         2:       begin lo = 'h80;    hi = 'h7FF;    end
         3:       begin lo = 'h800;   hi = 'hFFFF;   end
         default: begin lo = 'h10000; hi = 'h10FFFF; end
      endcase
      if ($urandom_range(3) == 0)
         cp = $urandom_range(1) ? lo : hi;
      else
         cp = $urandom_range(hi, lo);
      // Keep out of the surrogate range; land on its neighbors instead.
      if (len == 3 && cp >= 'hD800 && cp <= 'hDFFF)
         cp = $urandom_range(1) ? 'hD7FF : 'hE000;
      case (len)
         1: add_byte(8'(cp));
         2: begin
            add_byte(8'(8'hC0 | (cp >> 6)));
            add_byte(8'(8'h80 | (cp & 'h3F)));
         end
         3: begin
            add_byte(8'(8'hE0 | (cp >> 12)));
            add_byte(8'(8'h80 | ((cp >> 6) & 'h3F)));
            add_byte(8'(8'h80 | (cp & 'h3F)));
         end
         default: begin
            add_byte(8'(8'hF0 | (cp >> 18)));
            add_byte(8'(8'h80 | ((cp >> 12) & 'h3F)));
            add_byte(8'(8'h80 | ((cp >> 6) & 'h3F)));
            add_byte(8'(8'h80 | (cp & 'h3F)));
         end
      endcase
   endfunction

   // Build a short line of code points; when spoiled, break it in one of several ways.
   function automatic void build_line(int n_cp, bit spoil);
      int pick;
      line_buf.delete();
      repeat (n_cp) put_code_point($urandom_range(4, 1));
      if (!spoil)
         return;
      pick = $urandom_range(5);
      case (pick)
         0: if (line_buf.size() > 0)
               line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom());
         1: line_buf.insert($urandom_range(line_buf.size()), 8'($urandom()));
         2: if (line_buf.size() > 0)
               void'(line_buf.pop_back());
         3: begin
            // Lead byte followed by a second byte just outside its allowed range:
            // overlong, surrogate, overlong four-byte, above the last code point.
            case ($urandom_range(3))
               0: begin add_byte(8'hE0);
                        add_byte(8'($urandom_range(8'h9F, 8'h80))); end
               1: begin add_byte(8'hED);
                        add_byte(8'($urandom_range(8'hBF, 8'hA0))); end
               2: begin add_byte(8'hF0);
                        add_byte(8'($urandom_range(8'h8F, 8'h80))); end
               default: begin add_byte(8'hF4);
                        add_byte(8'($urandom_range(8'hBF, 8'h90))); end
            endcase
         end
         4: add_byte($urandom_range(1) ? 8'($urandom_range(8'hC1, 8'hC0))
                                       : 8'($urandom_range(8'hFF, 8'hF5)));
         default: add_byte(8'($urandom_range(8'hBF, 8'h80)));
      endcase
      // Let the decoder restart on good text after the break.
      if (pick >= 3)
         repeat ($urandom_range(2)) put_code_point($urandom_range(4, 1));
   endfunction

   // Request column: mostly around the line, sometimes negative, sometimes anything.
   function automatic int pick_column(int len);
      case ($urandom_range(9))
         0:       return int'($urandom());
         1:       return -int'($urandom_range(3, 1));
         default: return int'($urandom_range(len + 3, 0));
      endcase
   endfunction

   // Offer one item from the falling edge, wait for the handshake, note it, and
   // return at the next falling edge with tvalid still high.
   task automatic send_item(logic [7:0] b, bit has, bit eol, int col);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {col, b};
      req_tuser <= has;
      req_tlast <= eol;
      do @(posedge clock); while (!req_tready);
      tracker.take_item(b, has, eol, col);
      if (has || eol)
         items_sent++;
      @(negedge clock);
   endtask

   // Send line_buf as one line. An empty line is a lone line-end item without a byte;
   // a dry end closes the line with such an item after the last byte.
   task automatic send_line(int col, bit walk, bit dry_end);
      int n;
      n = line_buf.size();
      if (n == 0) begin
         send_item(8'($urandom()), 1'b0, 1'b1, col);
         return;
      end
      for (int i = 0; i < n; i++) begin
         // Drop in an ignored item now and then.
         if ($urandom_range(99) < noise_pct)
            send_item(8'($urandom()), 1'b0, 1'b0, col);
         send_item(line_buf[i], 1'b1, (i == n - 1) && !dry_end,
                   walk ? pick_column(n) : col);
      end
      if (dry_end)
         send_item(8'($urandom()), 1'b0, 1'b1, col);
   endtask

   initial begin
      int start_count;
      tracker = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed lines, no idling on either side.
      // Empty line: both columns read 0.
      line_buf = {};
      send_line(3, 1'b0, 1'b0);
      // Lowest and highest single bytes with the most negative column: clamp to 0.
      line_buf = {8'h00, 8'h7F};
      send_line(int'(32'h8000_0000), 1'b0, 1'b0);
      // Two-byte range ends with the largest column: snap to the line end.
      line_buf = {8'hC2, 8'h80, 8'hDF, 8'hBF};
      send_line(32'h7FFF_FFFF, 1'b0, 1'b0);
      // Highest code point, an ignored item inside it, and a dry line end.
      send_item(8'hF4, 1'b1, 1'b0, 4);
      send_item(8'h5A, 1'b0, 1'b0, 4);
      line_buf = {8'h8F, 8'hBF, 8'hBF};
      send_line(4, 1'b0, 1'b1);
      // Overlong three-byte form.
      line_buf = {8'hE0, 8'h9F, 8'h80};
      send_line(9, 1'b0, 1'b0);
      // Encoded surrogate.
      line_buf = {8'hED, 8'hA0, 8'h80};
      send_line(1, 1'b0, 1'b0);
      // Lead byte that can never start a sequence.
      line_buf = {8'hC1};
      send_line(0, 1'b0, 1'b0);
      // Sequence cut off by the line end.
      line_buf = {8'hE1, 8'h80};
      send_line(2, 1'b0, 1'b0);
      // Column changing within the line: each boundary meets its own column.
      send_item(8'h41, 1'b1, 1'b0, 0);
      send_item(8'h42, 1'b1, 1'b0, 2);
      send_item(8'h43, 1'b1, 1'b1, 1);

      // Random lines in four idling phases.
      noise_pct = 5;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct <= 0;
               // Hold the receiver off while short lines keep coming.
               pressure_go <= 1'b1;
            end
            1: begin send_idle_pct = 68; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 68; end
            default: begin send_idle_pct = 23; recv_stall_pct <= 23; end
         endcase
         start_count = items_sent;
         while (items_sent - start_count < PHASE_ITEMS) begin
            build_line(($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(8),
                       $urandom_range(9) < 3);
            send_line(pick_column(line_buf.size()), $urandom_range(7) == 0,
                      $urandom_range(9) == 0);
         end
         // Drain before the next phase.
         req_tvalid <= 1'b0;
         do @(negedge clock); while (tracker.pending() != 0);
      end

      // Let any stray result show up.
      repeat (10) @(posedge clock);
      if (tracker.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
